// ===== design/psd_pkg.sv =====
`default_nettype none
package psd_pkg;

	// field and datapath widths
	localparam int COORD_W    = 32;
	localparam int DIFF_W     = 33;
	localparam int MAG_W      = 33;
	localparam int PROD_W     = 65;
	localparam int SUM_W      = 68;
	localparam int REM_W      = 69;
	localparam int U_W        = 33;
	localparam int E_W        = 35;
	localparam int EMAG_W     = 34;
	localparam int ROOT_W     = 34;
	localparam int SQREM_W    = 37;
	localparam int DIST_W     = 33;
	localparam int MINLEN_W   = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROJECTION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		PROJ_FULL = 2'd0,
		PROJ_XY   = 2'd1,
		PROJ_YZ   = 2'd2,
		PROJ_ZX   = 2'd3
	} proj_t;

	typedef logic [2:0][COORD_W-1:0] vec_t;

	// side data that rides along with the division
	typedef struct packed {
		logic                    foot;
		logic                    zero_len;
		logic [SUM_W-1:0]        alt_sum;
		logic [2:0]              d_neg;
		logic [2:0][MAG_W-1:0]   d_mag;
		logic [2:0][DIFF_W-1:0]  w;
	} carry_t;

	// magnitude of a two's complement difference
	function automatic logic [MAG_W-1:0] mag(input logic [DIFF_W-1:0] v);
		mag = v[DIFF_W-1] ? (~v + 1'b1) : v;
	endfunction

	// product of two magnitudes, exact within PROD_W
	function automatic logic [PROD_W-1:0] mul_mag(input logic [MAG_W-1:0] x,
			input logic [MAG_W-1:0] y);
		logic [2*MAG_W-1:0] f;
		f = {{MAG_W{1'b0}}, x} * {{MAG_W{1'b0}}, y};
		mul_mag = f[PROD_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/psd_pts_if.sv =====
`default_nettype none
interface psd_pts_if;
	logic                               valid;
	logic                               ready;
	logic signed [psd_pkg::COORD_W-1:0] end_a_x;
	logic signed [psd_pkg::COORD_W-1:0] end_a_y;
	logic signed [psd_pkg::COORD_W-1:0] end_a_z;
	logic signed [psd_pkg::COORD_W-1:0] end_b_x;
	logic signed [psd_pkg::COORD_W-1:0] end_b_y;
	logic signed [psd_pkg::COORD_W-1:0] end_b_z;
	logic signed [psd_pkg::COORD_W-1:0] query_x;
	logic signed [psd_pkg::COORD_W-1:0] query_y;
	logic signed [psd_pkg::COORD_W-1:0] query_z;

	modport source(output valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
		query_x, query_y, query_z, input ready);
	modport sink(input valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
		query_x, query_y, query_z, output ready);
endinterface
`default_nettype wire

// ===== design/psd_res_if.sv =====
`default_nettype none
interface psd_res_if;
	logic                        valid;
	logic                        ready;
	logic [psd_pkg::DIST_W-1:0]  distance;

	modport source(output valid, distance, input ready);
	modport sink(input valid, distance, output ready);
endinterface
`default_nettype wire

// ===== design/point_segment_distance.sv =====
// pipeline: setup, divide, foot and root sections, in that order, from input transfer to result
// throughput: one item per cycle while the result is not stalled; the whole pipeline advances together
// a stalled result holds every stage, so nothing is lost or repeated
// reset: arst_n clears all stage valid bits, projection to full 3D, min_length to 1
`default_nettype none
module point_segment_distance (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [psd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [psd_pkg::CFG_DATA_W-1:0]   cfg_data,
	psd_pts_if.sink                               pts,
	psd_res_if.source                             res
);
	logic                            en;
	psd_pkg::proj_t                  proj_q;
	logic [psd_pkg::MINLEN_W-1:0]    min_length_q;
	psd_pkg::vec_t                   a_v, b_v, q_v;
	logic                            fr_vld, dv_vld, ft_vld, sq_vld;
	logic [psd_pkg::SUM_W-1:0]       fr_tt, fr_len2, ft_x;
	psd_pkg::carry_t                 fr_carry, dv_carry;
	logic [psd_pkg::U_W-1:0]         dv_u;
	logic [psd_pkg::ROOT_W-1:0]      sq_root;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_q       <= psd_pkg::PROJ_FULL;
			min_length_q <= psd_pkg::MINLEN_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				psd_pkg::REG_PROJECTION: proj_q <= psd_pkg::proj_t'(cfg_data[1:0]);
				psd_pkg::REG_MIN_LENGTH: min_length_q <= cfg_data[psd_pkg::MINLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline moves whenever the output stage is free or being drained
	assign en        = !sq_vld || res.ready;
	assign pts.ready = en;

	assign a_v = {pts.end_a_z, pts.end_a_y, pts.end_a_x};
	assign b_v = {pts.end_b_z, pts.end_b_y, pts.end_b_x};
	assign q_v = {pts.query_z, pts.query_y, pts.query_x};

	psd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.vld_i        (pts.valid),
		.a_i          (a_v),
		.b_i          (b_v),
		.q_i          (q_v),
		.proj_i       (proj_q),
		.min_length_i (min_length_q),
		.vld_o        (fr_vld),
		.tt_o         (fr_tt),
		.len2_o       (fr_len2),
		.carry_o      (fr_carry)
	);

	psd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (fr_vld),
		.tt_i    (fr_tt),
		.len2_i  (fr_len2),
		.carry_i (fr_carry),
		.vld_o   (dv_vld),
		.u_o     (dv_u),
		.carry_o (dv_carry)
	);

	psd_foot u_foot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (dv_vld),
		.u_i     (dv_u),
		.carry_i (dv_carry),
		.vld_o   (ft_vld),
		.x_o     (ft_x)
	);

	psd_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (ft_vld),
		.x_i    (ft_x),
		.vld_o  (sq_vld),
		.root_o (sq_root)
	);

	assign res.valid    = sq_vld;
	assign res.distance = sq_root[psd_pkg::DIST_W-1:0];

	// an empty output stage never blocks new input
	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> pts.ready)
		else $error("input blocked with empty output stage");

	// a held result freezes the pipeline, so the output valid stays set
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pts.ready |=> res.valid)
		else $error("result dropped during stall");
endmodule
`default_nettype wire

// ===== design/psd_front.sv =====
`default_nettype none
module psd_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            vld_i,
	input  wire psd_pkg::vec_t                   a_i,
	input  wire psd_pkg::vec_t                   b_i,
	input  wire psd_pkg::vec_t                   q_i,
	input  wire psd_pkg::proj_t                  proj_i,
	input  wire logic [psd_pkg::MINLEN_W-1:0]    min_length_i,
	output logic                                 vld_o,
	output logic [psd_pkg::SUM_W-1:0]            tt_o,
	output logic [psd_pkg::SUM_W-1:0]            len2_o,
	output psd_pkg::carry_t                      carry_o
);
	localparam int DW = psd_pkg::DIFF_W;
	localparam int MW = psd_pkg::MAG_W;
	localparam int PW = psd_pkg::PROD_W;
	localparam int SW = psd_pkg::SUM_W;
	localparam int CW = psd_pkg::COORD_W;
	localparam int LW = psd_pkg::MINLEN_W;

	logic [2:0]         keep;
	logic [2:0][DW-1:0] d_c, w_c, eb_c;
	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic [2:0][DW-1:0] d_s1, w_s1, eb_s1;
	logic [2:0][PW-1:0] pw_s2, dd_s2, ww_s2, ee_s2;
	logic [2:0]         neg_s2, d_neg_s2, d_neg_s3;
	logic [2:0][MW-1:0] d_mag_s2, d_mag_s3;
	logic [2:0][DW-1:0] w_s2, w_s3;
	logic [SW-1:0]      pos_c, neg_c, len2_c, sw_c, seb_c;
	logic [SW-1:0]      pos_s3, neg_s3, len2_s3, sw_s3, seb_s3;
	logic [2*LW-1:0]    m2_s3;
	logic [SW-1:0]      tt_c;
	logic               short_c, over_c;
	logic [SW-1:0]      tt_s4, len2_s4;
	psd_pkg::carry_t    carry_s4;

	// axes kept by the projection
	always_comb begin
		unique case (proj_i)
			psd_pkg::PROJ_FULL: keep = 3'b111;
			psd_pkg::PROJ_XY:   keep = 3'b011;
			psd_pkg::PROJ_YZ:   keep = 3'b110;
			psd_pkg::PROJ_ZX:   keep = 3'b101;
			default:            keep = 3'b111;
		endcase
	end

	// stage 1: differences
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_c[k]  = '0;
			w_c[k]  = '0;
			eb_c[k] = '0;
			if (keep[k]) begin
				d_c[k]  = {b_i[k][CW-1], b_i[k]} - {a_i[k][CW-1], a_i[k]};
				w_c[k]  = {q_i[k][CW-1], q_i[k]} - {a_i[k][CW-1], a_i[k]};
				eb_c[k] = {q_i[k][CW-1], q_i[k]} - {b_i[k][CW-1], b_i[k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= d_c;
			w_s1  <= w_c;
			eb_s1 <= eb_c;
		end
	end

	// stage 2: products and squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pw_s2[k]    <= psd_pkg::mul_mag(psd_pkg::mag(w_s1[k]), psd_pkg::mag(d_s1[k]));
				dd_s2[k]    <= psd_pkg::mul_mag(psd_pkg::mag(d_s1[k]), psd_pkg::mag(d_s1[k]));
				ww_s2[k]    <= psd_pkg::mul_mag(psd_pkg::mag(w_s1[k]), psd_pkg::mag(w_s1[k]));
				ee_s2[k]    <= psd_pkg::mul_mag(psd_pkg::mag(eb_s1[k]),
					psd_pkg::mag(eb_s1[k]));
				neg_s2[k]   <= w_s1[k][DW-1] ^ d_s1[k][DW-1];
				d_neg_s2[k] <= d_s1[k][DW-1];
				d_mag_s2[k] <= psd_pkg::mag(d_s1[k]);
			end
			w_s2 <= w_s1;
		end
	end

	// stage 3: sums
	always_comb begin
		pos_c  = '0;
		neg_c  = '0;
		len2_c = '0;
		sw_c   = '0;
		seb_c  = '0;
		for (int k = 0; k < 3; k++) begin
			if (neg_s2[k]) neg_c = neg_c + SW'(pw_s2[k]);
			else           pos_c = pos_c + SW'(pw_s2[k]);
			len2_c = len2_c + SW'(dd_s2[k]);
			sw_c   = sw_c + SW'(ww_s2[k]);
			seb_c  = seb_c + SW'(ee_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s3   <= pos_c;
			neg_s3   <= neg_c;
			len2_s3  <= len2_c;
			sw_s3    <= sw_c;
			seb_s3   <= seb_c;
			m2_s3    <= {{LW{1'b0}}, min_length_i} * {{LW{1'b0}}, min_length_i};
			d_neg_s3 <= d_neg_s2;
			d_mag_s3 <= d_mag_s2;
			w_s3     <= w_s2;
		end
	end

	// stage 4: pick the nearest feature
	assign tt_c    = pos_s3 - neg_s3;
	assign short_c = (len2_s3 < SW'(m2_s3)) || (pos_s3 < neg_s3);
	assign over_c  = len2_s3 < tt_c;

	always_ff @(posedge clk) begin
		if (en) begin
			tt_s4             <= tt_c;
			len2_s4           <= len2_s3;
			carry_s4.foot     <= !short_c && !over_c;
			carry_s4.zero_len <= len2_s3 == '0;
			carry_s4.alt_sum  <= short_c ? sw_s3 : seb_s3;
			carry_s4.d_neg    <= d_neg_s3;
			carry_s4.d_mag    <= d_mag_s3;
			carry_s4.w        <= w_s3;
		end
	end

	assign vld_o   = vld_s4;
	assign tt_o    = tt_s4;
	assign len2_o  = len2_s4;
	assign carry_o = carry_s4;
endmodule
`default_nettype wire

// ===== design/psd_div.sv =====
`default_nettype none
module psd_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vld_i,
	input  wire logic [psd_pkg::SUM_W-1:0]  tt_i,
	input  wire logic [psd_pkg::SUM_W-1:0]  len2_i,
	input  wire psd_pkg::carry_t            carry_i,
	output logic                            vld_o,
	output logic [psd_pkg::U_W-1:0]         u_o,
	output psd_pkg::carry_t                 carry_o
);
	localparam int N  = psd_pkg::U_W;
	localparam int RW = psd_pkg::REM_W;
	localparam int SW = psd_pkg::SUM_W;

	logic                   vld_s   [N];
	logic [RW-1:0]          rem_s   [N];
	logic [N-1:0]           quo_s   [N];
	logic [SW-1:0]          len_s   [N];
	psd_pkg::carry_t        carry_s [N];

	// one quotient bit per stage, restoring division
	for (genvar i = 0; i < N; i++) begin : g_bit
		logic [RW-1:0]   r_in;
		logic [N-1:0]    q_in;
		logic            v_in;
		logic [SW-1:0]   l_in;
		psd_pkg::carry_t c_in;
		logic            ge;

		if (i == 0) begin : g_first
			assign r_in = RW'(tt_i);
			assign q_in = '0;
			assign v_in = vld_i;
			assign l_in = len2_i;
			assign c_in = carry_i;
		end else begin : g_next
			assign r_in = {rem_s[i-1][RW-2:0], 1'b0};
			assign q_in = quo_s[i-1];
			assign v_in = vld_s[i-1];
			assign l_in = len_s[i-1];
			assign c_in = carry_s[i-1];
		end

		assign ge = r_in >= RW'(l_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]   <= ge ? (r_in - RW'(l_in)) : r_in;
				quo_s[i]   <= {q_in[N-2:0], ge};
				len_s[i]   <= l_in;
				carry_s[i] <= c_in;
			end
		end
	end

	assign vld_o   = vld_s[N-1];
	assign u_o     = quo_s[N-1];
	assign carry_o = carry_s[N-1];

	// the remainder of a foot-point division ends below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N-1] && carry_s[N-1].foot && !carry_s[N-1].zero_len
		|-> rem_s[N-1] < RW'(len_s[N-1]))
		else $error("division remainder not below divisor");
endmodule
`default_nettype wire

// ===== design/psd_foot.sv =====
`default_nettype none
module psd_foot (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vld_i,
	input  wire logic [psd_pkg::U_W-1:0]    u_i,
	input  wire psd_pkg::carry_t            carry_i,
	output logic                            vld_o,
	output logic [psd_pkg::SUM_W-1:0]       x_o
);
	localparam int UW = psd_pkg::U_W;
	localparam int MW = psd_pkg::MAG_W;
	localparam int EW = psd_pkg::E_W;
	localparam int XW = psd_pkg::EMAG_W;
	localparam int SW = psd_pkg::SUM_W;

	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	logic [UW-1:0]       u_c;
	logic [2:0][MW-1:0]  off_s1;
	psd_pkg::carry_t     carry_s1;
	logic [2:0][EW-1:0]  e_c;
	logic [2:0][XW-1:0]  emag_s2, emag_c;
	logic                foot_s2, foot_s3;
	logic [SW-1:0]       alt_s2, alt_s3;
	logic [2:0][SW-1:0]  sq_s3;
	logic [SW-1:0]       x_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: offset along the segment, truncated toward zero
	assign u_c = carry_i.zero_len ? '0 : u_i;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				// u is unsigned q1.32, so drop 32 fraction bits
				off_s1[k] <= MW'((({{MW{1'b0}}, u_c} * {{UW{1'b0}}, carry_i.d_mag[k]})
					>> (UW - 1)));
			end
			carry_s1 <= carry_i;
		end
	end

	// stage 2: error vector from the foot point
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (carry_s1.d_neg[k])
				e_c[k] = EW'($signed(carry_s1.w[k])) + {2'b00, off_s1[k]};
			else
				e_c[k] = EW'($signed(carry_s1.w[k])) - {2'b00, off_s1[k]};
			emag_c[k] = e_c[k][EW-1] ? XW'(~e_c[k] + 1'b1) : XW'(e_c[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			emag_s2 <= emag_c;
			foot_s2 <= carry_s1.foot;
			alt_s2  <= carry_s1.alt_sum;
		end
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s3[k] <= SW'({{XW{1'b0}}, emag_s2[k]} * {{XW{1'b0}}, emag_s2[k]});
			end
			foot_s3 <= foot_s2;
			alt_s3  <= alt_s2;
		end
	end

	// stage 4: squared distance of the chosen case
	always_ff @(posedge clk) begin
		if (en) begin
			x_s4 <= foot_s3 ? (sq_s3[0] + sq_s3[1] + sq_s3[2]) : alt_s3;
		end
	end

	assign vld_o = vld_s4;
	assign x_o   = x_s4;
endmodule
`default_nettype wire

// ===== design/psd_sqrt.sv =====
`default_nettype none
module psd_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vld_i,
	input  wire logic [psd_pkg::SUM_W-1:0]  x_i,
	output logic                            vld_o,
	output logic [psd_pkg::ROOT_W-1:0]      root_o
);
	localparam int N  = psd_pkg::ROOT_W;
	localparam int XW = psd_pkg::SUM_W;
	localparam int RW = psd_pkg::SQREM_W;

	logic          vld_s  [N];
	logic [RW-1:0] rem_s  [N];
	logic [N-1:0]  root_s [N];
	logic [XW-1:0] x_s    [N-1];

	// two radicand bits per stage, digit-by-digit square root
	for (genvar i = 0; i < N; i++) begin : g_dig
		logic [XW-1:0] x_in;
		logic [RW-1:0] r_in;
		logic [N-1:0]  q_in;
		logic          v_in;
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign x_in = x_i;
			assign r_in = '0;
			assign q_in = '0;
			assign v_in = vld_i;
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign r_in = rem_s[i-1];
			assign q_in = root_s[i-1];
			assign v_in = vld_s[i-1];
		end

		assign cur   = {r_in[RW-3:0], x_in[XW-1:XW-2]};
		assign trial = RW'({q_in, 2'b01});
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? (cur - trial) : cur;
				root_s[i] <= {q_in[N-2:0], ge};
			end
		end

		if (i < N - 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[i] <= {x_in[XW-3:0], 2'b00};
				end
			end
		end
	end

	assign vld_o  = vld_s[N-1];
	assign root_o = root_s[N-1];

	// a truncated root leaves at most twice the root as remainder
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N-1] |-> rem_s[N-1] <= RW'({root_s[N-1], 1'b0}))
		else $error("square root remainder out of range");
endmodule
`default_nettype wire
